/* rtl/bsg_pkg.sv */
// shared types and constants of the battery status and gauge block
// no dependencies; used by bsg_gauge and battery_status_and_gauge

package bsg_pkg;

    // gauge curve
    localparam int NUM_POINTS = 11;
    localparam int IDX_W      = $clog2(NUM_POINTS);
    localparam int LEVEL_W    = 16;
    localparam int PCT_W      = 7;
    localparam int VOLT_W     = 13;
    localparam int NUM_W      = 20;           // (level - left) * 10 + 5 fits here
    localparam int CNT_W      = $clog2(NUM_W);
    localparam int SUM_W      = NUM_W + 1;

    localparam logic [LEVEL_W-1:0] GAUGE_PTS [0:NUM_POINTS-1] = '{
        16'd47579, 16'd49598, 16'd50895, 16'd52481, 16'd53683, 16'd54259,
        16'd54788, 16'd55509, 16'd56278, 16'd56999, 16'd58393
    };

    localparam int GAUGE_STEP  = 10;
    localparam int GAUGE_ROUND = 5;
    localparam int PCT_MAX     = 100;
    localparam int VOLT_SCALE  = 18;

    // charge status codes
    localparam logic [2:0] STAT_NONE        = 3'd0;
    localparam logic [2:0] STAT_CHARGING    = 3'd1;
    localparam logic [2:0] STAT_CHARGED     = 3'd2;
    localparam logic [2:0] STAT_DISCHARGING = 3'd3;
    localparam logic [2:0] STAT_UNKNOWN     = 3'd4;

    // status byte ranges, indexed by status code; the lowest matching index wins
    localparam logic [7:0] STAT_LO [0:3] = '{8'd166, 8'd4,  8'd211, 8'd0};
    localparam logic [7:0] STAT_HI [0:3] = '{8'd210, 8'd62, 8'd255, 8'd3};

    // request kinds carried on tuser
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_RESULT = 1'b1;

    // sampling sequence phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_STATUS = 3'b010,
        PH_LEVEL  = 3'b100
    } phase_t;

endpackage

/* rtl/bsg_gauge.sv */
// fuel gauge unit: segment search and rounding divide on one shared subtractor
// depends on bsg_pkg

module bsg_gauge (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [bsg_pkg::LEVEL_W-1:0] level,
    output logic                        done,
    output logic [bsg_pkg::PCT_W-1:0]   pct
);

    typedef enum logic [5:0] {
        G_IDLE   = 6'b000001,
        G_SEARCH = 6'b000010,
        G_SPAN   = 6'b000100,
        G_OFFS   = 6'b001000,
        G_DIV    = 6'b010000,
        G_FIN    = 6'b100000
    } gstate_t;

    gstate_t                        state_reg, state_next;
    logic [bsg_pkg::LEVEL_W-1:0]    lvl_reg, lvl_next;
    logic [bsg_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [bsg_pkg::LEVEL_W-1:0]    span_reg, span_next;
    logic [bsg_pkg::LEVEL_W-1:0]    rem_reg, rem_next;
    logic [bsg_pkg::NUM_W-1:0]      num_reg, num_next;
    logic [bsg_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [bsg_pkg::PCT_W-1:0]      pct_reg, pct_next;
    logic                           done_reg, done_next;

    // shared subtractor
    logic [bsg_pkg::LEVEL_W:0]      sub_a, sub_b;
    logic [bsg_pkg::LEVEL_W+1:0]    sub_d;
    logic                           borrow;

    logic [bsg_pkg::IDX_W-1:0]      idx_m1;
    logic [bsg_pkg::LEVEL_W-1:0]    diff;
    logic [bsg_pkg::SUM_W-1:0]      sum;

    assign idx_m1 = idx_reg - bsg_pkg::IDX_W'(1);
    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow = sub_d[bsg_pkg::LEVEL_W+1];
    assign diff   = sub_d[bsg_pkg::LEVEL_W-1:0];
    assign sum    = bsg_pkg::SUM_W'(num_reg)
                  + bsg_pkg::SUM_W'(idx_m1) * bsg_pkg::SUM_W'(bsg_pkg::GAUGE_STEP);

    always_comb begin
        sub_a = '0;
        sub_b = '0;
        case (state_reg)
            G_SEARCH: begin
                sub_a = {1'b0, lvl_reg};
                sub_b = {1'b0, bsg_pkg::GAUGE_PTS[idx_reg]};
            end
            G_SPAN: begin
                sub_a = {1'b0, bsg_pkg::GAUGE_PTS[idx_reg]};
                sub_b = {1'b0, bsg_pkg::GAUGE_PTS[idx_m1]};
            end
            G_OFFS: begin
                sub_a = {1'b0, lvl_reg};
                sub_b = {1'b0, bsg_pkg::GAUGE_PTS[idx_m1]};
            end
            G_DIV: begin
                // trial subtract of the shifted remainder
                sub_a = {rem_reg, num_reg[bsg_pkg::NUM_W-1]};
                sub_b = {1'b0, span_reg};
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        idx_next   = idx_reg;
        span_next  = span_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        cnt_next   = cnt_reg;
        pct_next   = pct_reg;
        done_next  = 1'b0;
        case (state_reg)
            G_IDLE: begin
                if (start) begin
                    lvl_next   = level;
                    idx_next   = '0;
                    state_next = G_SEARCH;
                end
            end
            G_SEARCH: begin
                if (borrow) begin
                    if (idx_reg == '0) begin
                        // below the first point
                        pct_next   = '0;
                        done_next  = 1'b1;
                        state_next = G_IDLE;
                    end else begin
                        state_next = G_SPAN;
                    end
                end else if (idx_reg == bsg_pkg::IDX_W'(bsg_pkg::NUM_POINTS - 1)) begin
                    // at or above the last point
                    pct_next   = bsg_pkg::PCT_W'(bsg_pkg::PCT_MAX);
                    done_next  = 1'b1;
                    state_next = G_IDLE;
                end else begin
                    idx_next = idx_reg + bsg_pkg::IDX_W'(1);
                end
            end
            G_SPAN: begin
                span_next  = (diff == '0) ? bsg_pkg::LEVEL_W'(1) : diff;
                state_next = G_OFFS;
            end
            G_OFFS: begin
                num_next   = bsg_pkg::NUM_W'(diff) * bsg_pkg::NUM_W'(bsg_pkg::GAUGE_STEP)
                           + bsg_pkg::NUM_W'(bsg_pkg::GAUGE_ROUND);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = G_DIV;
            end
            G_DIV: begin
                // restoring divide, one quotient bit per cycle
                if (!borrow) begin
                    rem_next = diff;
                end else begin
                    rem_next = sub_a[bsg_pkg::LEVEL_W-1:0];
                end
                num_next = {num_reg[bsg_pkg::NUM_W-2:0], ~borrow};
                cnt_next = cnt_reg + bsg_pkg::CNT_W'(1);
                if (cnt_reg == bsg_pkg::CNT_W'(bsg_pkg::NUM_W - 1)) begin
                    state_next = G_FIN;
                end
            end
            G_FIN: begin
                if (sum > bsg_pkg::SUM_W'(bsg_pkg::PCT_MAX)) begin
                    pct_next = bsg_pkg::PCT_W'(bsg_pkg::PCT_MAX);
                end else begin
                    pct_next = sum[bsg_pkg::PCT_W-1:0];
                end
                done_next  = 1'b1;
                state_next = G_IDLE;
            end
            default: begin
                state_next = G_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= G_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        lvl_reg  <= lvl_next;
        idx_reg  <= idx_next;
        span_reg <= span_next;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        cnt_reg  <= cnt_next;
        pct_reg  <= pct_next;
    end

    assign done = done_reg;
    assign pct  = pct_reg;

endmodule

/* rtl/battery_status_and_gauge.sv */
// battery status sequencer and fuel gauge, top level
// depends on bsg_pkg and bsg_gauge

// One input word is either a sample request (tuser 0) or a converter result
// (tuser 1). A request while idle starts a status conversion; the status
// result's top byte picks none, charging, charged, discharging or unknown,
// and only discharging closes the sense switch and asks for a level
// conversion, whose result reopens the switch and is stored. Every input
// word gives exactly one output word with the conversion request, the switch
// and busy levels, the status, the stored level, its 0-100 percent on an
// 11-point curve and the coarse voltage code. A word's result is loaded once
// the gauge unit is done and the output register is free: the gauge unit
// walks the curve one point a cycle on a single shared subtractor, then runs
// a 20-step restoring divide on that same subtractor for levels between two
// points; below the first or at or above the last point the divide is
// skipped. s_tready is high only while no word is being worked on; a finished
// result waits in the output register without blocking the next word.

module battery_status_and_gauge (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] adc_result
    input  logic        s_tuser,   // [0] req_type

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [0] start_conversion, [1] channel_select,
                                   // [2] sense_switch, [3] busy_res,
                                   // [6:4] status_code, [22:7] level_raw,
                                   // [29:23] percent, [42:30] voltage_code,
                                   // [47:43] zero
);

    typedef enum logic [1:0] {
        T_IDLE = 2'b01,
        T_CALC = 2'b10
    } tstate_t;

    // sequencer state
    tstate_t                        state_reg, state_next;
    bsg_pkg::phase_t                phase_reg, phase_next;
    logic [2:0]                     status_reg, status_next;
    logic [bsg_pkg::LEVEL_W-1:0]    level_reg, level_next;
    logic                           sw_reg, sw_next;

    // per-word flags held until the result is loaded
    logic                           start_reg, start_next;
    logic                           chan_reg, chan_next;
    logic                           done_seen_reg, done_seen_next;

    // output register
    logic                           m_valid_reg, m_valid_next;
    logic [47:0]                    m_data_reg, m_data_next;

    logic                           accept;
    logic                           g_done;
    logic [bsg_pkg::PCT_W-1:0]      g_pct;
    logic [2:0]                     cls;
    logic [bsg_pkg::VOLT_W-1:0]     volt;
    logic                           out_free;
    logic                           load;

    function automatic logic [2:0] classify(input logic [7:0] b);
        logic [2:0] r;
        r = bsg_pkg::STAT_UNKNOWN;
        for (int s = 3; s >= 0; s--) begin
            if (b >= bsg_pkg::STAT_LO[s] && b <= bsg_pkg::STAT_HI[s]) begin
                r = 3'(s);
            end
        end
        return r;
    endfunction

    assign s_tready = (state_reg == T_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cls      = classify(s_tdata[15:8]);
    assign out_free = !m_valid_reg || m_tready;

    // result is ready on the done pulse or once it has been seen
    assign load     = (state_reg == T_CALC) && (g_done || done_seen_reg) && out_free;

    // (level >> 8) * 18
    assign volt     = bsg_pkg::VOLT_W'(level_reg[15:8]) * bsg_pkg::VOLT_W'(bsg_pkg::VOLT_SCALE);

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        status_next    = status_reg;
        level_next     = level_reg;
        sw_next        = sw_reg;
        start_next     = start_reg;
        chan_next      = chan_reg;
        done_seen_next = done_seen_reg;
        case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    start_next     = 1'b0;
                    chan_next      = 1'b0;
                    done_seen_next = 1'b0;
                    state_next     = T_CALC;
                    if (s_tuser == bsg_pkg::REQ_SAMPLE) begin
                        // requests while busy are ignored
                        if (phase_reg == bsg_pkg::PH_IDLE) begin
                            phase_next = bsg_pkg::PH_STATUS;
                            start_next = 1'b1;
                        end
                    end else if (phase_reg == bsg_pkg::PH_STATUS) begin
                        status_next = cls;
                        if (cls == bsg_pkg::STAT_DISCHARGING) begin
                            phase_next = bsg_pkg::PH_LEVEL;
                            sw_next    = 1'b1;
                            start_next = 1'b1;
                            chan_next  = 1'b1;
                        end else begin
                            phase_next = bsg_pkg::PH_IDLE;
                            level_next = '0;
                        end
                    end else if (phase_reg == bsg_pkg::PH_LEVEL) begin
                        sw_next    = 1'b0;
                        level_next = s_tdata;
                        phase_next = bsg_pkg::PH_IDLE;
                    end
                end
            end
            T_CALC: begin
                if (g_done) begin
                    done_seen_next = 1'b1;
                end
                if (load) begin
                    state_next = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = 1'b1;
            m_data_next  = {5'b0, volt, g_pct, level_reg, status_reg,
                            (phase_reg != bsg_pkg::PH_IDLE), sw_reg, chan_reg, start_reg};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_IDLE;
            phase_reg     <= bsg_pkg::PH_IDLE;
            status_reg    <= bsg_pkg::STAT_NONE;
            level_reg     <= '0;
            sw_reg        <= 1'b0;
            done_seen_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            status_reg    <= status_next;
            level_reg     <= level_next;
            sw_reg        <= sw_next;
            done_seen_reg <= done_seen_next;
            m_valid_reg   <= m_valid_next;
        end
        start_reg  <= start_next;
        chan_reg   <= chan_next;
        m_data_reg <= m_data_next;
    end

    // gauge recomputed from the stored level for every word
    bsg_gauge u_gauge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .level   (level_next),
        .done    (g_done),
        .pct     (g_pct)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // sense switch is closed only while the level conversion is pending
    a_sw_level: assert property (@(posedge aclk) disable iff (!aresetn)
        sw_reg |-> (phase_reg == bsg_pkg::PH_LEVEL))
        else $error("sense switch closed outside level phase");

    // level phase is entered only from a discharging status
    a_level_dis: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == bsg_pkg::PH_LEVEL) |-> (status_reg == bsg_pkg::STAT_DISCHARGING))
        else $error("level phase without discharging status");

    // gauge finishes only while a word is being worked on
    a_done_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        g_done |-> (state_reg == T_CALC))
        else $error("gauge done while idle");

    // a loaded result carries a percent within range
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (m_tdata[29:23] <= 7'(bsg_pkg::PCT_MAX)))
        else $error("percent out of range");
`endif

endmodule
